/* rtl/core/mtt_pkg.sv */
package mtt_pkg;

	localparam int unsigned TIMER_SLOTS_DEF = 16;
	localparam logic [15:0] MAX_WAIT_RST    = 16'd30000;

	// command kinds
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_ADD    = 3'd1;
	localparam logic [2:0] KIND_REMOVE = 3'd2;
	localparam logic [2:0] KIND_RESET  = 3'd3;
	localparam logic [2:0] KIND_CANCEL = 3'd4;

	// timer types
	localparam logic [1:0] TYPE_DEMAND = 2'd0;
	localparam logic [1:0] TYPE_ONCE   = 2'd1;
	localparam logic [1:0] TYPE_REPEAT = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	// result kinds
	localparam logic RES_STATUS = 1'b0;
	localparam logic RES_FIRE   = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] tmr_id;
		logic [1:0]  tmr_type;
		logic [30:0] tmo_ms;
		logic [31:0] user_tag;
		logic [15:0] elapsed_ms;
	} cmd_t;

	typedef struct packed {
		logic        result_kind;
		logic [15:0] result_id;
		logic [31:0] result_tag;
		logic [1:0]  status;
		logic [15:0] wait_ms;
		logic        last;
	} res_t;

	typedef struct packed {
		logic        used;
		logic        disarmed;
		logic [15:0] id;
		logic [1:0]  ttype;
		logic [30:0] timeout;
		logic [31:0] start;
		logic [31:0] tag;
	} slot_t;

	// per-slot findings of the head unit
	typedef struct packed {
		logic        claim;
		logic        fire;
		logic        live;
		logic [31:0] ahead;
	} head_info_t;

endpackage

/* rtl/core/multi_timer_table_unit.sv */
// Timer table of TIMER_SLOTS slots kept in a ring of cells that rotates one slot per cycle past
// a single head unit, held only while a fire result waits for the result side. The first turn of
// the ring applies the command, counts the due timers and works out the wait to the nearest
// deadline; then the status result is sent, and only when some timer is due a second turn sends
// one fire result per due timer in ascending slot order. The command side is stalled while an
// item is in work. The max_wait_ms register is written through cfg_data and is taken in any
// cycle; write it only while the block is idle.
module multi_timer_table_unit
	import mtt_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int unsigned IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_STAT,
		ST_FIRE
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [31:0]      clock_q;
	logic [15:0]      id_ctr_q;
	logic [15:0]      max_wait_q;
	logic [15:0]      wait_q;
	logic             done_q;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] fires_q;
	logic             res_valid_q;
	res_t             res_q;

	slot_t            ring [TIMER_SLOTS];
	slot_t            head_slot;
	head_info_t       info;
	logic             shift;
	logic             out_free;
	logic [15:0]      new_id;
	logic             pos_end;

	assign new_id   = id_ctr_q + 16'd1;
	assign out_free = !res_valid_q || !res_stall;
	assign pos_end  = (pos_q == IDX_W'(TIMER_SLOTS - 1));

	// ring rotates every cycle of a turn, held only when a fire waits for the output
	always_comb begin
		case (state_q)
			ST_CMD:  shift = 1'b1;
			ST_FIRE: shift = !info.fire || out_free;
			default: shift = 1'b0;
		endcase
	end

	// ring of slot cells, the head feeds the last cell
	for (genvar k = 0; k < TIMER_SLOTS; k++) begin : g_cell
		slot_t d;
		if (k == TIMER_SLOTS - 1) begin : g_tail
			assign d = head_slot;
		end else begin : g_mid
			assign d = ring[k+1];
		end
		mtt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (ring[k])
		);
	end

	mtt_head u_head (
		.slot_i    (ring[0]),
		.cmd_phase (state_q == ST_CMD),
		.done      (done_q),
		.cmd       (cmd_q),
		.clock_ms  (clock_q),
		.new_id    (new_id),
		.slot_o    (head_slot),
		.info      (info)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clock_q     <= 32'd0;
			id_ctr_q    <= 16'd1;
			max_wait_q  <= MAX_WAIT_RST;
			wait_q      <= 16'd0;
			done_q      <= 1'b0;
			pos_q       <= '0;
			fires_q     <= '0;
			res_valid_q <= 1'b0;
			cmd_q       <= '0;
			res_q       <= '0;
		end else begin
			if (cfg_valid) begin
				max_wait_q <= cfg_data;
			end
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						wait_q  <= max_wait_q;
						done_q  <= 1'b0;
						fires_q <= '0;
						pos_q   <= '0;
						if (cmd.kind == KIND_TICK) begin
							clock_q <= clock_q + {16'd0, cmd.elapsed_ms};
						end
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					done_q <= done_q | info.claim;
					if (info.fire) begin
						fires_q <= fires_q + CNT_W'(1);
					end
					if (info.live && info.ahead < {16'd0, wait_q}) begin
						wait_q <= info.ahead[15:0];
					end
					if (pos_end) begin
						pos_q   <= '0;
						state_q <= ST_STAT;
					end else begin
						pos_q <= pos_q + IDX_W'(1);
					end
				end
				ST_STAT: begin
					if (out_free) begin
						res_valid_q       <= 1'b1;
						res_q.result_kind <= RES_STATUS;
						res_q.result_tag  <= 32'd0;
						res_q.wait_ms     <= wait_q;
						res_q.last        <= (fires_q == '0);
						res_q.result_id   <= 16'd0;
						res_q.status      <= STAT_OK;
						case (cmd_q.kind)
							KIND_ADD: begin
								if (done_q) begin
									res_q.result_id <= new_id;
									id_ctr_q        <= new_id;
								end else begin
									res_q.status <= STAT_FULL;
								end
							end
							KIND_REMOVE, KIND_RESET, KIND_CANCEL: begin
								if (!done_q) begin
									res_q.status <= STAT_NOT_FOUND;
								end
							end
							default: begin
								res_q.status <= STAT_OK;
							end
						endcase
						state_q <= (fires_q == '0) ? ST_IDLE : ST_FIRE;
					end
				end
				ST_FIRE: begin
					if (info.fire && out_free) begin
						res_valid_q       <= 1'b1;
						res_q.result_kind <= RES_FIRE;
						res_q.result_id   <= ring[0].id;
						res_q.result_tag  <= ring[0].tag;
						res_q.status      <= STAT_OK;
						res_q.wait_ms     <= 16'd0;
						res_q.last        <= (fires_q == CNT_W'(1));
						fires_q           <= fires_q - CNT_W'(1);
					end
					if (shift) begin
						if (pos_end) begin
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// every due timer seen on the fire turn was counted on the command turn
	a_fire_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRE && info.fire) |-> (fires_q != '0))
		else $error("fire without a pending count");

	// the ring is back in slot order whenever no item is in work
	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pos_q == '0))
		else $error("ring not aligned at idle");

	// the last step of the fire turn leaves no fire result pending
	a_fires_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRE && shift && pos_end) |=> (fires_q == '0))
		else $error("fire results left over after the fire turn");

endmodule

/* rtl/core/mtt_cell.sv */
module mtt_cell
	import mtt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  slot_t d,
	output slot_t q
);

	slot_t slot_q;

	// slot contents move on with the ring, cleared on reset so the slot reads as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule

/* rtl/core/mtt_head.sv */
module mtt_head
	import mtt_pkg::*;
(
	input  slot_t       slot_i,
	input  logic        cmd_phase,
	input  logic        done,
	input  cmd_t        cmd,
	input  logic [31:0] clock_ms,
	input  logic [15:0] new_id,
	output slot_t       slot_o,
	output head_info_t  info
);

	slot_t       sc;
	slot_t       sf;
	logic [31:0] lag;
	logic        due;
	logic        claim;

	// apply the command to the first matching slot, or for an add to the first free slot
	always_comb begin
		sc = slot_i;
		claim = 1'b0;
		if (cmd_phase && !done) begin
			case (cmd.kind)
				KIND_ADD: begin
					if (!slot_i.used) begin
						sc.used     = 1'b1;
						sc.id       = new_id;
						sc.ttype    = cmd.tmr_type;
						sc.timeout  = cmd.tmo_ms;
						sc.start    = clock_ms;
						sc.tag      = cmd.user_tag;
						sc.disarmed = (cmd.tmr_type != TYPE_ONCE);
						claim       = 1'b1;
					end
				end
				KIND_REMOVE: begin
					if (slot_i.used && slot_i.id == cmd.tmr_id) begin
						sc.used = 1'b0;
						claim   = 1'b1;
					end
				end
				KIND_RESET: begin
					if (slot_i.used && slot_i.id == cmd.tmr_id) begin
						sc.timeout  = cmd.tmo_ms;
						sc.disarmed = 1'b0;
						sc.start    = clock_ms;
						claim       = 1'b1;
					end
				end
				KIND_CANCEL: begin
					if (slot_i.used && slot_i.id == cmd.tmr_id) begin
						sc.disarmed = 1'b1;
						claim       = 1'b1;
					end
				end
				default: begin
					sc = slot_i;
				end
			endcase
		end
	end

	// due check, modulo 2^32
	assign lag = clock_ms - sc.start - {1'b0, sc.timeout};
	assign due = sc.used && !sc.disarmed && !lag[31];

	// slot after firing
	always_comb begin
		sf = sc;
		if (due) begin
			if (sc.ttype == TYPE_ONCE) begin
				sf.used = 1'b0;
			end else begin
				sf.start = clock_ms;
				if (sc.ttype != TYPE_REPEAT) begin
					sf.disarmed = 1'b1;
				end
			end
		end
	end

	// a fired repeat is next due one timeout from now
	assign info.claim = claim;
	assign info.fire  = due;
	assign info.live  = sf.used && !sf.disarmed;
	assign info.ahead = due ? {1'b0, sc.timeout} : (32'd0 - lag);
	assign slot_o     = cmd_phase ? sc : sf;

endmodule
